// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Every property is sampled on the rising edge of clk and is off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge.
`define DCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define DCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define DCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Disciplined counter clock package
// Types, constants and saturating helpers shared by the sequencer and the
// serial multiply-divide unit.
// ----------------------------------------------------------------------------
package dcc_pkg;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [62:0] EPOCH_100NS = {31'h019DB1DE, 32'hD53E8000};

  localparam logic signed [63:0] TICKS_PER_SEC = 64'sd10000000;
  localparam logic signed [63:0] DRIFT_SPAN    = 64'sd20000000;
  localparam logic signed [63:0] FTD_LOW       = 64'sd9000000;
  localparam logic signed [63:0] FTD_HIGH      = 64'sd11000000;
  localparam logic signed [63:0] TDIFF_SMALL   = 64'sd100000;
  localparam logic signed [63:0] MUL_TENTHS_LO = 64'sd9;
  localparam logic signed [63:0] MUL_TENTHS_HI = 64'sd11;
  localparam logic signed [63:0] DIV_TEN       = 64'sd10;
  localparam logic signed [63:0] MUL_CLAMP_HI  = 64'sd1003;
  localparam logic signed [63:0] MUL_CLAMP_LO  = 64'sd997;
  localparam logic signed [63:0] DIV_THOUSAND  = 64'sd1000;
  localparam logic signed [63:0] MUL_FIVE      = 64'sd5;
  localparam logic signed [63:0] ONE           = 64'sd1;
  localparam logic signed [63:0] S64_MAX       = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN       = {1'b1, {63{1'b0}}};
  localparam logic signed [63:0] MASK60        = {4'd0, {60{1'b1}}};
  localparam logic signed [63:0] MASK40        = {24'd0, {40{1'b1}}};
  localparam logic [23:0]        TICKS_24      = 24'd10000000;
  localparam logic [6:0]         ELEVEN        = 7'd11;
  localparam logic [3:0]         IVAL_MAX      = 4'd10;
  localparam logic [5:0]         MD_LAST       = 6'd63;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL,
    MD_CHK,
    MD_DIV,
    MD_FIN
  } md_state_t;

  typedef enum logic [5:0] {
    S_IDLE,
    S_DECODE,
    S_FILL,
    S_WAIT,
    S_T_CHK,
    S_A_LIM9,
    S_A_LIM11,
    S_A_TEST,
    S_A_SPAN,
    S_A_EST,
    S_C_VT,
    S_C_VT2,
    S_C_TD,
    S_C_DR,
    S_C_DR2,
    S_C_DR3,
    S_C_DR4,
    S_C_DR5,
    S_C_DR6,
    S_C_HI,
    S_C_LO,
    S_C_CL,
    S_N0,
    S_N1,
    S_N2,
    S_N2B,
    S_N3,
    S_N4,
    S_N5,
    S_C_FIN,
    S_R0,
    S_R1,
    S_R2,
    S_R3,
    S_R_US,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              go;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] c;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic signed [63:0] q;
  } md_rsp_t;

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sadd = s[64] ? S64_MIN : S64_MAX;
    end else begin
      sadd = s[63:0];
    end
  endfunction

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      ssub = s[64] ? S64_MIN : S64_MAX;
    end else begin
      ssub = s[63:0];
    end
  endfunction

  function automatic logic abs_gt(input logic signed [63:0] v,
                                  input logic signed [63:0] lim);
    abs_gt = (v > lim) || (v < -lim);
  endfunction

endpackage

// ===== rtl/dcc_muldiv.sv =====
// ----------------------------------------------------------------------------
// Serial signed multiply-divide
// Computes a*b/c truncated toward zero with saturation, one product bit and
// then one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcc_muldiv import dcc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  md_req_t req,
  output md_rsp_t rsp
);

  md_state_t state, state_next;
  logic [5:0]  cnt, cnt_next;
  logic [63:0] hi, hi_next;
  logic [63:0] lo, lo_next;
  logic [63:0] ma, ma_next;
  logic [63:0] mc, mc_next;
  logic        neg, neg_next;
  logic        sat, sat_next;
  logic        zero, zero_next;
  logic [64:0] sum;
  logic [63:0] r2;
  logic        take;
  logic [63:0] qu;

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    mag = v[63] ? (64'd0 - v) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
    end else begin
      state <= state_next;
    end
    cnt  <= cnt_next;
    hi   <= hi_next;
    lo   <= lo_next;
    ma   <= ma_next;
    mc   <= mc_next;
    neg  <= neg_next;
    sat  <= sat_next;
    zero <= zero_next;
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    hi_next    = hi;
    lo_next    = lo;
    ma_next    = ma;
    mc_next    = mc;
    neg_next   = neg;
    sat_next   = sat;
    zero_next  = zero;
    sum        = {1'b0, hi} + (lo[0] ? {1'b0, ma} : 65'd0);
    r2         = {hi[62:0], lo[63]};
    take       = hi[63] || (r2 >= mc);
    case (state)
      MD_IDLE: begin
        if (req.go) begin
          zero_next  = (req.a == 64'sd0) || (req.b == 64'sd0);
          neg_next   = req.a[63] ^ req.b[63] ^ req.c[63];
          ma_next    = mag(req.a);
          mc_next    = mag(req.c);
          hi_next    = 64'd0;
          lo_next    = mag(req.b);
          sat_next   = 1'b0;
          cnt_next   = 6'd0;
          state_next = zero_next ? MD_FIN : MD_MUL;
        end
      end
      MD_MUL: begin
        hi_next  = sum[64:1];
        lo_next  = {sum[0], lo[63:1]};
        cnt_next = cnt + 6'd1;
        if (cnt == MD_LAST) begin
          state_next = MD_CHK;
        end
      end
      MD_CHK: begin
        if (hi >= mc) begin
          sat_next   = 1'b1;
          state_next = MD_FIN;
        end else begin
          cnt_next   = 6'd0;
          state_next = MD_DIV;
        end
      end
      MD_DIV: begin
        hi_next  = take ? (r2 - mc) : r2;
        lo_next  = {lo[62:0], take};
        cnt_next = cnt + 6'd1;
        if (cnt == MD_LAST) begin
          state_next = MD_FIN;
        end
      end
      MD_FIN: begin
        state_next = MD_IDLE;
      end
      default: begin
        state_next = MD_IDLE;
      end
    endcase
  end

  always_comb begin
    qu       = sat ? {64{1'b1}} : lo;
    rsp.done = (state == MD_FIN);
    if (zero) begin
      rsp.q = 64'sd0;
    end else if (neg) begin
      rsp.q = qu[63] ? S64_MIN : (64'd0 - qu);
    end else begin
      rsp.q = qu[63] ? S64_MAX : qu;
    end
  end

  `DCC_ASSERT_IMP(a_go_idle, req.go, state == MD_IDLE, "request while busy")
  `DCC_ASSERT_NEXT(a_done_pulse, rsp.done, !rsp.done, "done longer than one cycle")
  `DCC_ASSERT_IMP(a_rem_bound, state == MD_DIV, hi < mc, "remainder not below divisor")

endmodule

// ===== rtl/disciplined_counter_clock.sv =====
// ----------------------------------------------------------------------------
// Disciplined counter clock
// Keeps a wall clock from a free-running counter, steered by system time.
// ----------------------------------------------------------------------------
// Input beats carry kind (start, tick, read), a counter sample, the raw system
// time and a recheck counter; each input beat produces exactly one output beat
// with micros, hires_ok, freq_now and interval_now. One item is processed at a
// time; in_ready is high while the sequencer is idle, even if the previous
// result still waits on the output register.
// The scaling multiply-divide operations share one serial multiply-divide unit
// that forms 64 product bits and then 64 quotient bits per operation. A start
// refills the RING_DEPTH-entry sample ring, when usable, before it answers; in a
// full calibration tick a jump trades the span division for a RING_DEPTH refill,
// and a skipped tick goes straight to the result.
// Reset clears the clock state, sets the interval to 1 and loads the nominal
// frequency and usable flag defaults; the sample ring is written by start.
// When the receiver stalls, the result holds in the output register and the
// next item is accepted but its result waits until the register frees up.
// Configuration is written through cfg_write, cfg_index and cfg_data.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module disciplined_counter_clock import dcc_pkg::*; #(
  parameter int RING_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [62:0] counter,
  input  logic [62:0] file_time,
  input  logic [62:0] recheck_counter,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [59:0] micros,
  output logic        hires_ok,
  output logic [39:0] freq_now,
  output logic [3:0]  interval_now,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [39:0] cfg_data
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

  state_t state, state_next;
  state_t ret, ret_next;
  state_t fret, fret_next;
  logic        started, started_next;
  logic        running, running_next;
  logic [39:0] nom, nom_next;
  logic        usable, usable_next;
  logic [1:0]  kind_q, kind_next;
  logic signed [63:0] cq, cq_next;
  logic signed [63:0] ft, ft_next;
  logic signed [63:0] rc, rc_next;
  logic signed [63:0] bt, bt_next;
  logic signed [63:0] bc, bc_next;
  logic signed [63:0] df, df_next;
  logic signed [63:0] last, last_next;
  logic signed [63:0] est, est_next;
  logic signed [63:0] vt0, vt0_next;
  logic signed [63:0] tdiff, tdiff_next;
  logic signed [63:0] x, x_next;
  logic signed [63:0] y, y_next;
  logic signed [63:0] t1, t1_next;
  logic signed [63:0] mq, mq_next;
  logic signed [63:0] us, us_next;
  logic signed [63:0] fill_c, fill_c_next;
  logic signed [63:0] fill_t, fill_t_next;
  logic [AW-1:0] fill_i, fill_i_next;
  logic [AW-1:0] pos, pos_next;
  logic [3:0]  ival, ival_next;
  logic        out_valid_next;
  logic [59:0] micros_q, micros_next;
  logic        hires_q, hires_next;
  logic [39:0] freq_q, freq_next;
  logic [3:0]  ival_q, ival_q_next;

  logic signed [63:0] ring_count [RING_DEPTH];
  logic signed [63:0] ring_time  [RING_DEPTH];
  logic signed [63:0] rcnt_q, rtim_q;
  logic               ring_we, ring_re;
  logic [AW-1:0]      ring_wa, ring_ra;
  logic signed [63:0] ring_wc, ring_wt;

  md_req_t md_req;
  md_rsp_t md_rsp;

  logic signed [63:0] nom_s;
  logic signed [63:0] ft_in;
  logic [27:0]        ival_ticks;
  logic signed [63:0] lim;
  logic [AW-1:0]      prev_pos;
  logic [AW-1:0]      pos_inc;
  logic signed [63:0] span;
  logic signed [63:0] half_x;
  logic signed [63:0] sum8;
  logic signed [63:0] us_clip;

  dcc_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_count[ring_wa] <= ring_wc;
      ring_time[ring_wa]  <= ring_wt;
    end
    if (ring_re) begin
      rcnt_q <= ring_count[ring_ra];
      rtim_q <= ring_time[ring_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      started   <= 1'b0;
      running   <= 1'b1;
      nom       <= 40'd10000000;
      usable    <= 1'b1;
      bt        <= 64'sd0;
      bc        <= 64'sd0;
      df        <= 64'sd0;
      last      <= 64'sd0;
      pos       <= '0;
      ival      <= 4'd1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      started   <= started_next;
      running   <= running_next;
      nom       <= nom_next;
      usable    <= usable_next;
      bt        <= bt_next;
      bc        <= bc_next;
      df        <= df_next;
      last      <= last_next;
      pos       <= pos_next;
      ival      <= ival_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ret      <= ret_next;
    fret     <= fret_next;
    kind_q   <= kind_next;
    cq       <= cq_next;
    ft       <= ft_next;
    rc       <= rc_next;
    est      <= est_next;
    vt0      <= vt0_next;
    tdiff    <= tdiff_next;
    x        <= x_next;
    y        <= y_next;
    t1       <= t1_next;
    mq       <= mq_next;
    us       <= us_next;
    fill_c   <= fill_c_next;
    fill_t   <= fill_t_next;
    fill_i   <= fill_i_next;
    micros_q <= micros_next;
    hires_q  <= hires_next;
    freq_q   <= freq_next;
    ival_q   <= ival_q_next;
  end

  always_comb begin
    nom_s      = {24'd0, nom};
    ft_in      = (file_time >= EPOCH_100NS) ? {1'b0, file_time - EPOCH_100NS} : 64'sd0;
    ival_ticks = ival * TICKS_24;
    lim        = last + {36'd0, ival_ticks};
    prev_pos   = (pos == '0) ? LAST_IDX : (pos - 1'b1);
    pos_inc    = (pos == LAST_IDX) ? '0 : (pos + 1'b1);
    span       = ssub(ft, rtim_q);
    half_x     = (x + $signed({63'd0, x[63]})) >>> 1;
    sum8       = sadd(y, x);
    us_clip    = us[63] ? 64'sd0 : ((us > MASK60) ? MASK60 : us);

    state_next     = state;
    ret_next       = ret;
    fret_next      = fret;
    started_next   = started;
    running_next   = running;
    nom_next       = nom;
    usable_next    = usable;
    kind_next      = kind_q;
    cq_next        = cq;
    ft_next        = ft;
    rc_next        = rc;
    bt_next        = bt;
    bc_next        = bc;
    df_next        = df;
    last_next      = last;
    est_next       = est;
    vt0_next       = vt0;
    tdiff_next     = tdiff;
    x_next         = x;
    y_next         = y;
    t1_next        = t1;
    mq_next        = mq;
    us_next        = us;
    fill_c_next    = fill_c;
    fill_t_next    = fill_t;
    fill_i_next    = fill_i;
    pos_next       = pos;
    ival_next      = ival;
    micros_next    = micros_q;
    hires_next     = hires_q;
    freq_next      = freq_q;
    ival_q_next    = ival_q;
    out_valid_next = out_valid && !out_ready;
    in_ready       = (state == S_IDLE);
    ring_we        = 1'b0;
    ring_wa        = fill_i;
    ring_wc        = fill_c;
    ring_wt        = fill_t;
    ring_re        = 1'b0;
    ring_ra        = pos;
    md_req.go      = 1'b0;
    md_req.a       = 64'sd0;
    md_req.b       = 64'sd0;
    md_req.c       = 64'sd0;

    if (cfg_write) begin
      if (cfg_index) begin
        usable_next = cfg_data[0];
      end else begin
        nom_next = cfg_data;
      end
    end

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          kind_next  = kind;
          cq_next    = {1'b0, counter};
          rc_next    = {1'b0, recheck_counter};
          ft_next    = ft_in;
          us_next    = 64'sd0;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (kind_q)
          KIND_START: begin
            started_next = 1'b1;
            running_next = usable;
            state_next   = S_DONE;
            if (usable) begin
              bc_next     = cq;
              df_next     = nom_s;
              bt_next     = ft;
              ival_next   = 4'd1;
              last_next   = 64'sd0;
              fill_c_next = cq;
              fill_t_next = ft;
              fill_i_next = LAST_IDX;
              fret_next   = S_DONE;
              state_next  = S_FILL;
            end
          end
          KIND_TICK: begin
            state_next = (started && running) ? S_T_CHK : S_DONE;
          end
          KIND_READ: begin
            state_next = S_R0;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_FILL: begin
        ring_we     = 1'b1;
        fill_c_next = ssub(fill_c, nom_s);
        fill_t_next = ssub(fill_t, TICKS_PER_SEC);
        fill_i_next = fill_i - 1'b1;
        if (fill_i == '0) begin
          pos_next   = '0;
          state_next = fret;
        end
      end
      S_WAIT: begin
        if (md_rsp.done) begin
          mq_next    = md_rsp.q;
          state_next = ret;
        end
      end
      S_T_CHK: begin
        if ((ft > last) && (ft < lim)) begin
          state_next = S_DONE;
        end else begin
          last_next = ft;
          if (df == 64'sd0) begin
            running_next = 1'b0;
            state_next   = S_DONE;
          end else begin
            ring_re    = 1'b1;
            ring_ra    = prev_pos;
            state_next = S_A_LIM9;
          end
        end
      end
      S_A_LIM9: begin
        x_next     = ssub(cq, rcnt_q);
        y_next     = ssub(ft, rtim_q);
        md_req.go  = 1'b1;
        md_req.a   = nom_s;
        md_req.b   = MUL_TENTHS_LO;
        md_req.c   = DIV_TEN;
        ret_next   = S_A_LIM11;
        state_next = S_WAIT;
      end
      S_A_LIM11: begin
        t1_next    = mq;
        md_req.go  = 1'b1;
        md_req.a   = nom_s;
        md_req.b   = MUL_TENTHS_HI;
        md_req.c   = DIV_TEN;
        ret_next   = S_A_TEST;
        state_next = S_WAIT;
      end
      S_A_TEST: begin
        if ((x < t1) || (x > mq) || (y < FTD_LOW) || (y > FTD_HIGH)) begin
          est_next    = nom_s;
          fill_c_next = cq;
          fill_t_next = ft;
          fill_i_next = LAST_IDX;
          fret_next   = S_C_VT;
          state_next  = S_FILL;
        end else begin
          ring_re    = 1'b1;
          ring_ra    = pos;
          state_next = S_A_SPAN;
        end
      end
      S_A_SPAN: begin
        ring_we  = 1'b1;
        ring_wa  = pos;
        ring_wc  = cq;
        ring_wt  = ft;
        pos_next = pos_inc;
        if (span == 64'sd0) begin
          est_next   = nom_s;
          state_next = S_C_VT;
        end else begin
          md_req.go  = 1'b1;
          md_req.a   = ssub(cq, rcnt_q);
          md_req.b   = TICKS_PER_SEC;
          md_req.c   = span;
          ret_next   = S_A_EST;
          state_next = S_WAIT;
        end
      end
      S_A_EST: begin
        est_next   = mq;
        state_next = S_C_VT;
      end
      S_C_VT: begin
        md_req.go  = 1'b1;
        md_req.a   = ssub(cq, bc);
        md_req.b   = TICKS_PER_SEC;
        md_req.c   = df;
        ret_next   = S_C_VT2;
        state_next = S_WAIT;
      end
      S_C_VT2: begin
        vt0_next   = sadd(bt, mq);
        state_next = S_C_TD;
      end
      S_C_TD: begin
        tdiff_next = ssub(vt0, ft);
        if (abs_gt(tdiff_next, TICKS_PER_SEC)) begin
          vt0_next   = ft;
          state_next = S_C_HI;
        end else begin
          state_next = S_C_DR;
        end
      end
      S_C_DR: begin
        md_req.go  = 1'b1;
        md_req.a   = est;
        md_req.b   = DRIFT_SPAN;
        md_req.c   = DRIFT_SPAN - tdiff;
        ret_next   = S_C_DR2;
        state_next = S_WAIT;
      end
      S_C_DR2: begin
        x_next     = ssub(mq, df);
        state_next = S_C_DR3;
      end
      S_C_DR3: begin
        x_next     = sadd(df, half_x);
        state_next = S_C_DR4;
      end
      S_C_DR4: begin
        md_req.go  = 1'b1;
        md_req.a   = x;
        md_req.b   = MUL_FIVE;
        md_req.c   = ONE;
        ret_next   = S_C_DR5;
        state_next = S_WAIT;
      end
      S_C_DR5: begin
        y_next     = sadd(est, {df[62:0], 1'b0});
        x_next     = mq;
        state_next = S_C_DR6;
      end
      S_C_DR6: begin
        est_next   = (sum8 + $signed({61'd0, {3{sum8[63]}}})) >>> 3;
        state_next = S_C_HI;
      end
      S_C_HI: begin
        md_req.go  = 1'b1;
        md_req.a   = nom_s;
        md_req.b   = MUL_CLAMP_HI;
        md_req.c   = DIV_THOUSAND;
        ret_next   = S_C_LO;
        state_next = S_WAIT;
      end
      S_C_LO: begin
        t1_next    = mq;
        md_req.go  = 1'b1;
        md_req.a   = nom_s;
        md_req.b   = MUL_CLAMP_LO;
        md_req.c   = DIV_THOUSAND;
        ret_next   = S_C_CL;
        state_next = S_WAIT;
      end
      S_C_CL: begin
        if (est > t1) begin
          est_next   = t1;
          vt0_next   = ft;
          state_next = S_C_FIN;
        end else if (est < mq) begin
          est_next   = mq;
          vt0_next   = ft;
          state_next = S_C_FIN;
        end else if (vt0 != ft) begin
          state_next = S_N0;
        end else begin
          state_next = S_C_FIN;
        end
      end
      S_N0: begin
        md_req.go  = 1'b1;
        md_req.a   = ssub(rc, bc);
        md_req.b   = TICKS_PER_SEC;
        md_req.c   = df;
        ret_next   = S_N1;
        state_next = S_WAIT;
      end
      S_N1: begin
        x_next = sadd(bt, mq);
        if (est == 64'sd0) begin
          y_next     = vt0;
          state_next = S_N3;
        end else begin
          state_next = S_N2;
        end
      end
      S_N2: begin
        md_req.go  = 1'b1;
        md_req.a   = ssub(rc, cq);
        md_req.b   = TICKS_PER_SEC;
        md_req.c   = est;
        ret_next   = S_N2B;
        state_next = S_WAIT;
      end
      S_N2B: begin
        y_next     = sadd(vt0, mq);
        state_next = S_N3;
      end
      S_N3: begin
        if (x > y) begin
          x_next     = ssub(x, y);
          state_next = S_N4;
        end else begin
          state_next = S_C_FIN;
        end
      end
      S_N4: begin
        vt0_next   = sadd(vt0, x);
        state_next = S_N5;
      end
      S_N5: begin
        if (abs_gt(ssub(vt0, ft), TICKS_PER_SEC)) begin
          vt0_next = ft;
        end
        state_next = S_C_FIN;
      end
      S_C_FIN: begin
        if (abs_gt(tdiff, TDIFF_SMALL)) begin
          ival_next = 4'd1;
        end else if (ival < IVAL_MAX) begin
          ival_next = ival + 4'd1;
        end
        bt_next    = vt0;
        df_next    = est;
        bc_next    = cq;
        state_next = S_DONE;
      end
      S_R0: begin
        if (!started || !running || !usable || (df <= 64'sd0)) begin
          state_next = S_DONE;
        end else if (cq <= bc) begin
          md_req.go  = 1'b1;
          md_req.a   = bt;
          md_req.b   = ONE;
          md_req.c   = DIV_TEN;
          ret_next   = S_R_US;
          state_next = S_WAIT;
        end else begin
          md_req.go  = 1'b1;
          md_req.a   = df;
          md_req.b   = {57'd0, ival * ELEVEN};
          md_req.c   = DIV_TEN;
          ret_next   = S_R1;
          state_next = S_WAIT;
        end
      end
      S_R1: begin
        if ((cq - bc) < mq) begin
          md_req.go  = 1'b1;
          md_req.a   = ssub(cq, bc);
          md_req.b   = TICKS_PER_SEC;
          md_req.c   = df;
          ret_next   = S_R2;
          state_next = S_WAIT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_R2: begin
        x_next     = sadd(bt, mq);
        state_next = S_R3;
      end
      S_R3: begin
        md_req.go  = 1'b1;
        md_req.a   = x;
        md_req.b   = ONE;
        md_req.c   = DIV_TEN;
        ret_next   = S_R_US;
        state_next = S_WAIT;
      end
      S_R_US: begin
        us_next    = mq;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          micros_next    = us_clip[59:0];
          hires_next     = (us_clip != 64'sd0);
          freq_next      = df[63] ? 40'd0 : ((df > MASK40) ? MASK40[39:0] : df[39:0]);
          ival_q_next    = ival;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign micros       = micros_q;
  assign hires_ok     = hires_q;
  assign freq_now     = freq_q;
  assign interval_now = ival_q;

  `DCC_ASSERT(a_ival_range, ival >= 4'd1 && ival <= IVAL_MAX, "interval out of range")
  `DCC_ASSERT_NEXT(a_go_wait, md_req.go, state == S_WAIT, "request without wait")
  `DCC_ASSERT_IMP(a_hires, out_valid, hires_q == (micros_q != 60'd0), "hires flag mismatch")

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Disciplined counter clock testbench
// Drives start, calibration tick, read and ignored items through the
// valid/ready input channel. Each accepted item is run through a local model
// of the clock (sample ring, frequency estimate, drift, clamp, no-backwards
// check) and the predicted result is matched field by field with the output
// beats. Both channels idle at random, and the configuration moves through
// several nominal frequencies and the usable flag while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import dcc_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic REG_NOMINAL = 1'b0;
  localparam logic REG_USABLE  = 1'b1;
  localparam longint SEC   = 64'sd10000000;
  localparam longint DRIFT = 64'sd20000000;
  localparam longint SMAX  = 64'sh7FFFFFFFFFFFFFFF;
  localparam longint SMIN  = 64'sh8000000000000000;
  localparam longint M63   = 64'sh7FFFFFFFFFFFFFFF;
  localparam longint M60   = 64'sh0FFFFFFFFFFFFFFF;
  localparam longint M40   = 64'sh000000FFFFFFFFFF;

  typedef struct {
    logic [1:0]  kind;
    logic [62:0] counter;
    logic [62:0] file_time;
    logic [62:0] recheck;
  } item_t;

  typedef struct {
    logic [59:0] micros;
    logic        hires_ok;
    logic [39:0] freq_now;
    logic [3:0]  interval_now;
  } clock_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = '0;
  logic [62:0] counter = '0;
  logic [62:0] file_time = '0;
  logic [62:0] recheck_counter = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [59:0] micros;
  logic hires_ok;
  logic [39:0] freq_now;
  logic [3:0] interval_now;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [39:0] cfg_data = '0;

  disciplined_counter_clock dut (.*);

  item_t pending_items[$];
  clock_result_t expected_results[$];
  int errors = 0;
  bit in_took = 0;
  bit out_took = 0;
  bit calm = 0;
  int in_gap = 0;
  int out_stall = 0;
  bit next_valid;
  item_t cur;

  // Local copy of the clock state and configuration.
  longint nominal;
  bit usable;
  bit started, running;
  longint base_time, base_count, disc_freq, last_cal;
  int cal_ival, ring_pos;
  longint ring_cnt[64], ring_tim[64];

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint s_add(longint a, longint b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
    return s[63:0];
  endfunction

  function automatic longint s_sub(longint a, longint b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
    return s[63:0];
  endfunction

  function automatic longint unsigned scale_u(longint unsigned a, longint unsigned b,
                                              longint unsigned c);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:64] >= c) return '1;
    return 64'(p / {64'd0, c});
  endfunction

  function automatic longint scale_s(longint a, longint b, longint c);
    bit neg;
    longint unsigned q, ma, mb, mc;
    if (a == 0 || b == 0) return 0;
    neg = (a < 0) ^ (b < 0) ^ (c < 0);
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    mc = c < 0 ? -c : c;
    q = scale_u(ma, mb, mc);
    if (neg) return q >= 64'h8000000000000000 ? SMIN : -longint'(q);
    return q > 64'h7FFFFFFFFFFFFFFF ? SMAX : longint'(q);
  endfunction

  function automatic longint wall_time(longint t0, longint c0, longint f, longint c);
    return s_add(t0, scale_s(s_sub(c, c0), SEC, f));
  endfunction

  function automatic bit beyond(longint v, longint lim);
    return v > lim || v < -lim;
  endfunction

  function automatic void refill_ring(longint t, longint c, longint f);
    for (int i = 63; i >= 0; i--) begin
      ring_cnt[i] = c;
      ring_tim[i] = t;
      c = s_sub(c, f);
      t = s_sub(t, SEC);
    end
    ring_pos = 0;
  endfunction

  function automatic longint ring_estimate(longint c, longint t);
    int prev;
    longint pcd, ftd, span, est;
    prev = (ring_pos + 63) % 64;
    pcd = s_sub(c, ring_cnt[prev]);
    ftd = s_sub(t, ring_tim[prev]);
    if (pcd < nominal * 9 / 10 || pcd > nominal * 11 / 10 ||
        ftd < 9000000 || ftd > 11000000) begin
      refill_ring(t, c, nominal);
      return nominal;
    end
    span = s_sub(t, ring_tim[ring_pos]);
    est = span == 0 ? nominal : scale_s(s_sub(c, ring_cnt[ring_pos]), SEC, span);
    ring_cnt[ring_pos] = c;
    ring_tim[ring_pos] = t;
    ring_pos = (ring_pos + 1) % 64;
    return est;
  endfunction

  function automatic void discipline(longint c, longint ft, longint rc);
    longint est, vt0, tdiff, hi, lo, drift, nt0, nt1;
    if (ft > last_cal && ft < last_cal + longint'(cal_ival) * SEC) return;
    last_cal = ft;
    if (disc_freq == 0) begin
      running = 0;
      return;
    end
    est = ring_estimate(c, ft);
    vt0 = wall_time(base_time, base_count, disc_freq, c);
    tdiff = s_sub(vt0, ft);
    if (beyond(tdiff, SEC)) begin
      vt0 = ft;
    end else begin
      drift = scale_s(est, DRIFT, DRIFT - tdiff);
      drift = s_add(disc_freq, s_sub(drift, disc_freq) / 2);
      est = s_add(s_add(est, 2 * disc_freq), scale_s(drift, 5, 1)) / 8;
    end
    hi = 1003 * nominal / 1000;
    lo = 997 * nominal / 1000;
    if (est > hi) begin
      est = hi;
      vt0 = ft;
    end else if (est < lo) begin
      est = lo;
      vt0 = ft;
    end else if (vt0 != ft) begin
      nt0 = wall_time(base_time, base_count, disc_freq, rc);
      nt1 = est == 0 ? vt0 : wall_time(vt0, c, est, rc);
      if (nt0 > nt1) begin
        vt0 = s_add(vt0, s_sub(nt0, nt1));
        if (beyond(s_sub(vt0, ft), SEC)) vt0 = ft;
      end
    end
    if (beyond(tdiff, 100000)) cal_ival = 1;
    else if (cal_ival < 10) cal_ival++;
    base_time = vt0;
    disc_freq = est;
    base_count = c;
  endfunction

  function automatic longint read_clock(longint c);
    longint unsigned delta, limit;
    if (!started || !running || !usable || disc_freq <= 0) return 0;
    if (c <= base_count) return base_time / 10;
    delta = c - base_count;
    limit = 11 * longint'(disc_freq) * cal_ival / 10;
    if (delta < limit) return wall_time(base_time, base_count, disc_freq, c) / 10;
    return 0;
  endfunction

  function automatic clock_result_t advance_clock(item_t it);
    clock_result_t r;
    longint c, ft, rc, us;
    c = longint'({1'b0, it.counter});
    rc = longint'({1'b0, it.recheck});
    ft = it.file_time >= EPOCH_100NS ? longint'({1'b0, it.file_time - EPOCH_100NS}) : 0;
    us = 0;
    case (it.kind)
      KIND_START: begin
        started = 1;
        running = usable;
        if (running) begin
          base_count = c;
          disc_freq = nominal;
          base_time = ft;
          cal_ival = 1;
          last_cal = 0;
          refill_ring(ft, c, disc_freq);
        end
      end
      KIND_TICK: begin
        if (started && running) discipline(c, ft, rc);
      end
      KIND_READ: us = read_clock(c);
      default: ;
    endcase
    if (us < 0) us = 0;
    if (us > M60) us = M60;
    r.micros = us[59:0];
    r.hires_ok = us != 0;
    r.freq_now = disc_freq < 0 ? 40'd0 : (disc_freq > M40 ? '1 : disc_freq[39:0]);
    r.interval_now = cal_ival[3:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_took = 0;
      out_took = 0;
    end else begin
      in_took = in_valid && in_ready;
      out_took = out_valid && out_ready;
      if (in_took) expected_results.push_back(advance_clock(
          '{kind: kind, counter: counter, file_time: file_time, recheck: recheck_counter}));
      if (out_took) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat: micros=%0d", micros);
        end else begin
          clock_result_t e;
          e = expected_results.pop_front();
          if (e.micros !== micros || e.hires_ok !== hires_ok ||
              e.freq_now !== freq_now || e.interval_now !== interval_now) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp micros=%0d ok=%0d freq=%0d ival=%0d, got %0d %0d %0d %0d",
                       e.micros, e.hires_ok, e.freq_now, e.interval_now,
                       micros, hires_ok, freq_now, interval_now);
          end
        end
      end
    end
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  always @(negedge clk) begin
    if (!rst) begin
      if ($urandom_range(0, 199) == 0) calm = !calm;
      next_valid = in_valid;
      if (in_valid && in_took) next_valid = 0;
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() != 0) begin
          cur = pending_items.pop_front();
          kind <= cur.kind;
          counter <= cur.counter;
          file_time <= cur.file_time;
          recheck_counter <= cur.recheck;
          next_valid = 1;
          in_gap = draw_gap();
        end
      end
      in_valid <= next_valid;
      if (out_ready && out_took) out_stall = draw_gap();
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic longint rand63();
    return {$urandom, $urandom} & M63;
  endfunction

  function automatic void add_item(logic [1:0] k, longint c, longint ft, longint rc);
    pending_items.push_back('{kind: k, counter: c[62:0], file_time: ft[62:0],
                              recheck: rc[62:0]});
  endfunction

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, longint value);
    wait_idle();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[39:0];
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_NOMINAL) nominal = value & M40;
    else usable = value[0];
  endtask

  task automatic run_session(longint f, int n);
    longint raw, c, fe, jit, ppm, step, rc;
    int k, r;
    fe = f == 0 ? SEC : f;
    raw = (longint'(EPOCH_100NS) + ({$urandom, $urandom} & 64'h003FFFFFFFFFFFFF)) & M63;
    c = rand63() >> 2;
    add_item(KIND_START, c, raw, 0);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (r < 12) begin
        k = $urandom_range(0, 6) == 0 ? $urandom_range(2, 12) : 1;
        jit = $urandom_range(0, 9) == 0 ? longint'($urandom_range(0, 6000000)) - 3000000
                                        : longint'($urandom_range(0, 120000)) - 60000;
        ppm = $urandom_range(0, 9) == 0 ? longint'($urandom_range(0, 300000)) - 150000
                                        : longint'($urandom_range(0, 8000)) - 4000;
        raw = (raw + k * SEC + jit) & M63;
        step = k * fe;
        c = (c + step + (step / 1000) * ppm / 1000) & M63;
        rc = (c + fe / 1000 * $urandom_range(0, 1000)) & M63;
        add_item(KIND_TICK, c, raw, rc);
      end else if (r < 18) begin
        step = fe / 1000 * $urandom_range(0, 2500);
        if ($urandom_range(0, 7) == 0) step = -step;
        add_item(KIND_READ, (c + step) & M63, rand63(), rand63());
      end else if (r == 18) begin
        add_item(2'($urandom_range(0, 3)), rand63(), rand63(), rand63());
      end else begin
        add_item(KIND_START, c, raw, rand63());
      end
    end
  endtask

  initial begin
    nominal = 10000000;
    usable = 1;
    started = 0;
    running = 1;
    base_time = 0;
    base_count = 0;
    disc_freq = 0;
    last_cal = 0;
    cal_ival = 1;
    ring_pos = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_item(KIND_READ, 1000, 0, 0);
    add_item(KIND_TICK, 1000, M63, M63);
    add_item(KIND_NONE, M63, M63, M63);
    add_item(KIND_START, M63, M63, M63);
    add_item(KIND_READ, M63, 0, 0);
    add_item(KIND_TICK, M63, M63, M63);
    add_item(KIND_START, 0, 0, 0);
    add_item(KIND_READ, 0, 0, 0);
    add_item(KIND_TICK, 10000000, 5, 10000000);
    add_item(KIND_START, 64'sd5000000000, longint'(EPOCH_100NS) + 64'sd15000000000000000, 0);
    add_item(KIND_READ, 64'sd5005000000, 0, 0);
    add_item(KIND_READ, 64'sd4000000000, 0, 0);
    add_item(KIND_READ, 64'sd5500000000, 0, 0);
    add_item(KIND_TICK, 64'sd5009990000, longint'(EPOCH_100NS) + 64'sd15000000009990000,
             64'sd5010000000);
    add_item(KIND_TICK, 64'sd5010000000, longint'(EPOCH_100NS) + 64'sd15000000010000000,
             64'sd5012000000);
    add_item(KIND_TICK, 64'sd5020100000, longint'(EPOCH_100NS) + 64'sd15000000020000000,
             64'sd5020500000);
    add_item(KIND_TICK, 64'sd5030000000, longint'(EPOCH_100NS) + 64'sd15000000045000000,
             64'sd5030000000);
    add_item(KIND_READ, 64'sd5030000001, 0, 0);
    add_item(KIND_NONE, 0, 0, 0);
    add_item(KIND_READ, 64'sd5030000000, M63, M63);
    run_session(64'sd10000000, 150);

    write_reg(REG_NOMINAL, M40);
    run_session(M40, 150);
    write_reg(REG_NOMINAL, 0);
    run_session(0, 60);
    write_reg(REG_USABLE, 0);
    write_reg(REG_NOMINAL, 64'sd10000000);
    run_session(64'sd10000000, 60);
    write_reg(REG_USABLE, 1);
    write_reg(REG_NOMINAL, 1);
    run_session(1, 120);
    begin
      longint f;
      f = longint'($urandom_range(1000000, 32'hF0000000));
      write_reg(REG_NOMINAL, f);
      run_session(f, 250);
    end
    write_reg(REG_NOMINAL, 64'sd3579545);
    run_session(64'sd3579545, 400);

    wait_idle();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #400000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
